/* rtl/lzcb_pkg.sv */
// Shared constants and types for the LZ control-byte decompressor.
// No dependencies; lzcb_window, lzcb_packer and the decompressor refer to it by scoped names.
package lzcb_pkg;

	localparam int WINDOW_BYTES = 4096;
	localparam int WIN_AW       = $clog2(WINDOW_BYTES);
	localparam int LANE_BYTES   = 8;
	localparam int LANE_MAX     = 8;
	localparam int HDR_BYTES    = 4;
	localparam int CTRL_ITEMS   = 8;
	localparam int LEN_MIN      = 3;
	localparam int LEN_EXT      = 18;
	localparam logic [3:0] NIB_EXT = 4'hf;

	typedef struct packed {
		logic              en;
		logic [WIN_AW-1:0] addr;
		logic [7:0]        data;
	} win_wr_t;

	typedef struct packed {
		logic push;
		logic clear;
	} pk_ctl_t;

endpackage

/* rtl/lzcb_in_if.sv */
// Input channel: one compressed byte per item plus end-of-block mark.
// Uses no package.
interface lzcb_in_if;
	logic       valid;
	logic       ready;
	logic [7:0] in_byte;
	logic       in_last;

	modport source (output valid, output in_byte, output in_last, input ready);
	modport sink (input valid, input in_byte, input in_last, output ready);
endinterface

/* rtl/lzcb_out_if.sv */
// Output channel: packed decoded bytes with end-of-run and block status.
// Uses no package.
interface lzcb_out_if;
	logic        valid;
	logic        ready;
	logic [63:0] out_data;
	logic [3:0]  out_count;
	logic        run_last;
	logic        block_done;
	logic        status;

	modport source (output valid, output out_data, output out_count, output run_last,
		output block_done, output status, input ready);
	modport sink (input valid, input out_data, input out_count, input run_last,
		input block_done, input status, output ready);
endinterface

/* rtl/lzcb_window.sv */
// History window: one write port, one registered read port.
// Depends on lzcb_pkg (window size, write port struct).
module lzcb_window (
	input  logic                          clk,
	input  lzcb_pkg::win_wr_t             wr,
	input  logic [lzcb_pkg::WIN_AW-1:0]   rd_addr,
	output logic [7:0]                    rd_data
);

	logic [7:0] mem [lzcb_pkg::WINDOW_BYTES];
	logic [7:0] rd_q;
	logic [7:0] byp_data_q;
	logic       byp_q;

	always_ff @(posedge clk) begin
		if (wr.en) begin
			mem[wr.addr] <= wr.data;
		end
	end

	always_ff @(posedge clk) begin
		rd_q <= mem[rd_addr];
	end

	// read of the entry being written this cycle returns the new byte
	always_ff @(posedge clk) begin
		byp_q      <= wr.en && (wr.addr == rd_addr);
		byp_data_q <= wr.data;
	end

	assign rd_data = byp_q ? byp_data_q : rd_q;

endmodule

/* rtl/lzcb_packer.sv */
// Packing lane: collects copied bytes, earliest byte in the low bits.
// Depends on lzcb_pkg (control struct, lane size).
module lzcb_packer (
	input  logic              clk,
	input  logic              arst_n,
	input  lzcb_pkg::pk_ctl_t ctl,
	input  logic [7:0]        din,
	output logic [63:0]       data,
	output logic [3:0]        cnt
);

	logic [63:0] data_q;
	logic [3:0]  cnt_q;
	logic [63:0] data_push;

	always_comb begin
		data_push = data_q;
		for (int i = 0; i < lzcb_pkg::LANE_MAX; i++) begin
			if (cnt_q[2:0] == 3'(i)) begin
				data_push[8*i +: 8] = din;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			data_q <= '0;
			cnt_q  <= '0;
		end else if (ctl.clear) begin
			data_q <= '0;
			cnt_q  <= '0;
		end else if (ctl.push) begin
			data_q <= data_push;
			cnt_q  <= cnt_q + 4'd1;
		end
	end

	assign data = data_q;
	assign cnt  = cnt_q;

endmodule

/* rtl/lz_control_byte_decompressor.sv */
// LZ control-byte block decompressor.
//
// din carries one compressed byte per item, in_last on the final byte of a
// block. The first four bytes give the decoded size (little-endian), then
// control bytes each govern eight literals or tags. dout carries decoded
// bytes packed up to LANE_BYTES per item; run_last marks the last item
// caused by one input byte, block_done with status closes the block.
//
// Header, control and literal bytes are decoded as they are taken; a literal,
// or a block close on a byte that starts no copy, appears on dout the cycle
// after it is taken. A tag of length L is copied through the single window
// read port and the packing lane after it is taken, and din.ready stays low
// until the copy ends.
//
// Reset clears all decoder control state; the window contents stay undefined, as a
// tag only reads bytes written earlier in the same block. When dout stalls
// the output register holds its item and din.ready drops until it is taken.
// Depends on lzcb_pkg, lzcb_in_if, lzcb_out_if, lzcb_window, lzcb_packer.
module lz_control_byte_decompressor #(
	parameter int LANE_BYTES = lzcb_pkg::LANE_BYTES
) (
	input  logic       clk,
	input  logic       arst_n,
	lzcb_in_if.sink    din,
	lzcb_out_if.source dout
);

	localparam logic ST_IDLE = 1'b0;
	localparam logic ST_COPY = 1'b1;

	localparam logic [1:0] PH_NONE   = 2'd0;
	localparam logic [1:0] PH_SECOND = 2'd1;
	localparam logic [1:0] PH_EXTRA  = 2'd2;

	localparam int AW = lzcb_pkg::WIN_AW;

	logic        st_q;
	logic [31:0] exp_q;
	logic [2:0]  hidx_q;
	logic [31:0] prod_q;
	logic [7:0]  ctrl_q;
	logic [3:0]  items_q;
	logic [1:0]  phase_q;
	logic [7:0]  first_q;
	logic [7:0]  second_q;
	logic        err_q;

	logic [31:0] n_exp;
	logic [2:0]  n_hidx;
	logic [31:0] n_prod;
	logic [7:0]  n_ctrl;
	logic [3:0]  n_items;
	logic [1:0]  n_phase;
	logic [7:0]  n_first;
	logic [7:0]  n_second;
	logic        n_err;
	logic        fin_err;
	logic        lit;
	logic        run;
	logic        go;
	logic [8:0]  len;
	logic [11:0] off;
	logic [32:0] prod_len;

	logic        acc;
	logic        out_free;

	logic [8:0]    cp_left_q;
	logic          pend_q;
	logic [AW-1:0] rd_ptr_q;
	logic [AW-1:0] wr_ptr_q;
	logic          cp_done_q;
	logic          cp_stat_q;
	logic          issue;
	logic          fin;
	logic          flush;

	logic        out_valid_q;
	logic [63:0] out_data_q;
	logic [3:0]  out_count_q;
	logic        out_run_last_q;
	logic        out_done_q;
	logic        out_status_q;

	lzcb_pkg::win_wr_t win_wr;
	logic [7:0]        win_rdata;
	lzcb_pkg::pk_ctl_t pk_ctl;
	logic [63:0]       pk_data;
	logic [3:0]        pk_cnt;

	assign out_free  = !out_valid_q || dout.ready;
	assign din.ready = (st_q == ST_IDLE) && out_free;
	assign acc       = din.valid && din.ready;

	// decode of one input byte
	always_comb begin
		n_exp    = exp_q;
		n_hidx   = hidx_q;
		n_ctrl   = ctrl_q;
		n_items  = items_q;
		n_phase  = phase_q;
		n_first  = first_q;
		n_second = second_q;
		n_err    = err_q;
		lit      = 1'b0;
		run      = 1'b0;
		go       = 1'b0;
		if (phase_q == PH_SECOND) begin
			len = 9'(first_q[3:0]) + 9'(lzcb_pkg::LEN_MIN);
			off = {first_q[7:4], din.in_byte};
		end else begin
			len = 9'(lzcb_pkg::LEN_EXT) + 9'(din.in_byte);
			off = {first_q[7:4], second_q};
		end
		prod_len = {1'b0, prod_q} + 33'(len);

		if (err_q) begin
			n_err = 1'b1;
		end else if (hidx_q < 3'(lzcb_pkg::HDR_BYTES)) begin
			n_exp[{hidx_q[1:0], 3'b000} +: 8] = din.in_byte;
			n_hidx = hidx_q + 3'd1;
		end else if (phase_q == PH_SECOND) begin
			n_second = din.in_byte;
			if (first_q[3:0] == lzcb_pkg::NIB_EXT) begin
				n_phase = PH_EXTRA;
			end else begin
				run = 1'b1;
			end
		end else if (phase_q == PH_EXTRA) begin
			run = 1'b1;
		end else if (items_q == 4'd0) begin
			if (prod_q >= exp_q) begin
				n_err = 1'b1;
			end else begin
				n_ctrl  = din.in_byte;
				n_items = 4'(lzcb_pkg::CTRL_ITEMS);
			end
		end else if (ctrl_q[0]) begin
			n_first = din.in_byte;
			n_phase = PH_SECOND;
		end else if (prod_q >= exp_q) begin
			n_err = 1'b1;
		end else begin
			lit = 1'b1;
		end

		if (run) begin
			if (off == 12'd0 || {20'd0, off} > prod_q) begin
				n_err = 1'b1;
			end else if (prod_len > {1'b0, exp_q}) begin
				n_err = 1'b1;
			end else begin
				go = 1'b1;
			end
		end

		// advance to the next item under the control byte
		if (run || lit) begin
			n_ctrl  = ctrl_q >> 1;
			n_items = (items_q != 4'd0) ? items_q - 4'd1 : 4'd0;
			n_phase = PH_NONE;
		end

		n_prod  = go ? prod_len[31:0] : prod_q + 32'(lit);
		fin_err = n_err || (din.in_last && (n_hidx < 3'(lzcb_pkg::HDR_BYTES) ||
			n_phase != PH_NONE || n_prod != n_exp));
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			exp_q    <= '0;
			hidx_q   <= '0;
			prod_q   <= '0;
			ctrl_q   <= '0;
			items_q  <= '0;
			phase_q  <= PH_NONE;
			first_q  <= '0;
			second_q <= '0;
			err_q    <= 1'b0;
		end else if (acc) begin
			if (din.in_last) begin
				exp_q    <= '0;
				hidx_q   <= '0;
				prod_q   <= '0;
				ctrl_q   <= '0;
				items_q  <= '0;
				phase_q  <= PH_NONE;
				first_q  <= '0;
				second_q <= '0;
				err_q    <= 1'b0;
			end else begin
				exp_q    <= n_exp;
				hidx_q   <= n_hidx;
				prod_q   <= n_prod;
				ctrl_q   <= n_ctrl;
				items_q  <= n_items;
				phase_q  <= n_phase;
				first_q  <= n_first;
				second_q <= n_second;
				err_q    <= n_err;
			end
		end
	end

	// copy sequencer: one window read issued per cycle while the lane has room
	always_comb begin
		issue = (st_q == ST_COPY) && (cp_left_q != 9'd0) &&
			((pk_cnt + 4'(pend_q)) < 4'(LANE_BYTES));
		fin   = (cp_left_q == 9'd0) && !pend_q;
		flush = (st_q == ST_COPY) && out_free &&
			((pk_cnt == 4'(LANE_BYTES)) || (fin && pk_cnt != 4'd0));
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q      <= ST_IDLE;
			cp_left_q <= '0;
			pend_q    <= 1'b0;
		end else begin
			case (st_q)
				ST_IDLE: begin
					pend_q <= 1'b0;
					if (acc && go) begin
						st_q      <= ST_COPY;
						cp_left_q <= len;
					end
				end
				ST_COPY: begin
					pend_q <= issue;
					if (issue) begin
						cp_left_q <= cp_left_q - 9'd1;
					end
					if (flush && fin) begin
						st_q <= ST_IDLE;
					end
				end
				default: begin
					st_q   <= ST_IDLE;
					pend_q <= 1'b0;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (acc && go) begin
			rd_ptr_q  <= prod_q[AW-1:0] - off;
			wr_ptr_q  <= prod_q[AW-1:0];
			cp_done_q <= din.in_last;
			cp_stat_q <= fin_err;
		end else begin
			if (issue) begin
				rd_ptr_q <= rd_ptr_q + AW'(1);
			end
			if (pend_q) begin
				wr_ptr_q <= wr_ptr_q + AW'(1);
			end
		end
	end

	always_comb begin
		win_wr.en   = 1'b0;
		win_wr.addr = wr_ptr_q;
		win_wr.data = win_rdata;
		if (acc && lit) begin
			win_wr.en   = 1'b1;
			win_wr.addr = prod_q[AW-1:0];
			win_wr.data = din.in_byte;
		end else if (pend_q) begin
			win_wr.en = 1'b1;
		end
	end

	assign pk_ctl.push  = pend_q;
	assign pk_ctl.clear = flush;

	lzcb_window u_window (
		.clk     (clk),
		.wr      (win_wr),
		.rd_addr (rd_ptr_q),
		.rd_data (win_rdata)
	);

	lzcb_packer u_packer (
		.clk    (clk),
		.arst_n (arst_n),
		.ctl    (pk_ctl),
		.din    (win_rdata),
		.data   (pk_data),
		.cnt    (pk_cnt)
	);

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (flush || (acc && !go && (lit || din.in_last))) begin
			out_valid_q <= 1'b1;
		end else if (dout.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (flush) begin
			out_data_q     <= pk_data;
			out_count_q    <= pk_cnt;
			out_run_last_q <= fin;
			out_done_q     <= fin && cp_done_q;
			out_status_q   <= fin && cp_done_q && cp_stat_q;
		end else if (acc && !go && (lit || din.in_last)) begin
			out_data_q     <= lit ? {56'd0, din.in_byte} : 64'd0;
			out_count_q    <= lit ? 4'd1 : 4'd0;
			out_run_last_q <= 1'b1;
			out_done_q     <= din.in_last;
			out_status_q   <= din.in_last && fin_err;
		end
	end

	assign dout.valid      = out_valid_q;
	assign dout.out_data   = out_data_q;
	assign dout.out_count  = out_count_q;
	assign dout.run_last   = out_run_last_q;
	assign dout.block_done = out_done_q;
	assign dout.status     = out_status_q;

endmodule
